// ===== rtl/core/skit_pkg.sv =====
// ----------------------------------------------------------------------------
// skit_pkg
// shared types and codes for the sorted key index table
// ----------------------------------------------------------------------------
package skit_pkg;

    localparam int KEY_W  = 31;
    localparam int OFF_W  = 32;
    localparam int SIZE_W = 16;
    localparam int POS_W  = 8;
    localparam int FILL_W = 9;

    // operation codes
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [KEY_W-1:0]  key;
        logic [OFF_W-1:0]  entry_offset;
        logic [SIZE_W-1:0] entry_size;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [POS_W-1:0]  position;
        logic [OFF_W-1:0]  found_offset;
        logic [SIZE_W-1:0] found_size;
        logic [FILL_W-1:0] fill_count;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
    } entry_t;

    // compare flags a cell hands to its right neighbor
    typedef struct packed {
        logic le;
        logic eq;
    } cell_flags_t;

    // broadcast to every cell
    typedef struct packed {
        logic   write_en;
        entry_t new_entry;
    } cell_ctrl_t;

    typedef struct packed {
        logic              hit;
        logic [POS_W-1:0]  position;
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
    } lookup_t;

endpackage

// ===== rtl/core/skit_cell.sv =====
// ----------------------------------------------------------------------------
// skit_cell
// one table slot: holds an entry, compares it with the broadcast key and
// takes the new entry or its left neighbor's entry on an insert
// ----------------------------------------------------------------------------
module skit_cell
    import skit_pkg::*;
(
    input  logic        clk,
    input  logic        occupied,
    input  cell_ctrl_t  ctrl,
    input  cell_flags_t left_flags,
    input  entry_t      left_entry,
    output cell_flags_t flags,
    output entry_t      entry,
    output logic        hit
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        flags.le = occupied && (entry_reg.key <= ctrl.new_entry.key);
        flags.eq = occupied && (entry_reg.key == ctrl.new_entry.key);
        // first match of the contiguous run of equal keys
        hit      = flags.eq && !left_flags.eq;
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.write_en)
        begin
            if (flags.le)
            begin
                entry_next = entry_reg;
            end
            else if (left_flags.le)
            begin
                entry_next = ctrl.new_entry;
            end
            else
            begin
                entry_next = left_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/core/skit_reduce.sv =====
// ----------------------------------------------------------------------------
// skit_reduce
// and-or reduction of the one-hot first-match flags to position and data
// ----------------------------------------------------------------------------
module skit_reduce
    import skit_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic [CAPACITY-1:0] hit,
    input  entry_t              entries [CAPACITY],
    output lookup_t             result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int PW    = (IDX_W > POS_W) ? IDX_W : POS_W;

    logic [IDX_W-1:0]  pos_acc;
    logic [PW-1:0]     pos_wide;
    logic [OFF_W-1:0]  off_acc;
    logic [SIZE_W-1:0] size_acc;

    always_comb
    begin
        pos_acc  = '0;
        off_acc  = '0;
        size_acc = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            pos_acc  = pos_acc  | ({IDX_W{hit[i]}}  & IDX_W'(i));
            off_acc  = off_acc  | ({OFF_W{hit[i]}}  & entries[i].offset);
            size_acc = size_acc | ({SIZE_W{hit[i]}} & entries[i].size);
        end
        pos_wide        = PW'(pos_acc);
        result.hit      = |hit;
        result.position = pos_wide[POS_W-1:0];
        result.offset   = off_acc;
        result.size     = size_acc;
    end

endmodule

// ===== rtl/core/sorted_key_index_table.sv =====
// ----------------------------------------------------------------------------
// sorted_key_index_table
// key/offset/size index kept in ascending key order in a row of cells
// ----------------------------------------------------------------------------
//
//  channel | signals                   | moves
//  --------+---------------------------+---------------------------------------
//  req     | req_valid, req_ready, req | insert, lookup or clear request
//  rsp     | rsp_valid, rsp_ready, rsp | status, match data and fill count
//
//  insert, clear and unused codes register their result at the accepting edge;
//  a non-full insert compares all keys in parallel and shifts larger ones right
//  lookup registers the per-cell first-match flags at the accepting edge, then
//  in the lookup state reduces them through the and-or tree into the result
//  reset clears the fill count, the state and the result valid; cell contents
//  are not reset, a cell at or above the fill count is never looked at
//  a request is taken only when idle, the result register free or being drained
//
module sorted_key_index_table
    import skit_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int FW    = (CNT_W > FILL_W) ? CNT_W : FILL_W;

    // state codes
    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    logic             state_reg,     state_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg,       rsp_next;
    logic [CAPACITY-1:0] hit_reg,    hit_next;

    logic        out_free;
    logic        accept;
    logic        full;
    logic        load_rsp;
    logic [FW-1:0] fill_wide;

    cell_ctrl_t  ctrl;
    cell_flags_t cell_flags [CAPACITY];
    entry_t      cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_hit;
    lookup_t     look;

    // handshake
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req_valid && req_ready;
    assign full      = (count_reg >= CNT_W'(CAPACITY));

    // broadcast to the cells; only a non-full insert shifts the row
    assign ctrl.write_en         = accept && (req.func == FUNC_INSERT) && !full;
    assign ctrl.new_entry.key    = req.key;
    assign ctrl.new_entry.offset = req.entry_offset;
    assign ctrl.new_entry.size   = req.entry_size;

    // cell row, cell 0 sees a left neighbor that is always below the key
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
            cell_flags_t lf;
            entry_t      le;
            logic        occ;

            assign occ = (IDX < count_reg);

            if (gi == 0)
            begin : g_first
                assign lf.le = 1'b1;
                assign lf.eq = 1'b0;
                assign le    = ctrl.new_entry;
            end
            else
            begin : g_rest
                assign lf = cell_flags[gi-1];
                assign le = cell_entry[gi-1];
            end

            skit_cell u_cell (
                .clk        (clk),
                .occupied   (occ),
                .ctrl       (ctrl),
                .left_flags (lf),
                .left_entry (le),
                .flags      (cell_flags[gi]),
                .entry      (cell_entry[gi]),
                .hit        (cell_hit[gi])
            );
        end
    endgenerate

    // lookup state: registered one-hot flags to position and data
    skit_reduce #(
        .CAPACITY (CAPACITY)
    ) u_reduce (
        .hit     (hit_reg),
        .entries (cell_entry),
        .result  (look)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        hit_next       = hit_reg;
        load_rsp       = 1'b0;

        rsp_next.position     = rsp_reg.position;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.func)
                        FUNC_INSERT:
                        begin
                            load_rsp        = 1'b1;
                            rsp_next        = '0;
                            if (full)
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FUNC_LOOKUP:
                        begin
                            hit_next   = cell_hit;
                            state_next = S_LOOK;
                        end
                        FUNC_CLEAR:
                        begin
                            load_rsp   = 1'b1;
                            rsp_next   = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            // unused code: no change, plain done status
                            load_rsp = 1'b1;
                            rsp_next = '0;
                        end
                    endcase
                end
            end
            S_LOOK:
            begin
                if (out_free)
                begin
                    load_rsp   = 1'b1;
                    rsp_next   = '0;
                    state_next = S_IDLE;
                    if (look.hit)
                    begin
                        rsp_next.status       = ST_OK;
                        rsp_next.position     = look.position;
                        rsp_next.found_offset = look.offset;
                        rsp_next.found_size   = look.size;
                    end
                    else
                    begin
                        rsp_next.status = ST_MISS;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // fill count after the operation, low bits only
        fill_wide = FW'(count_next);
        if (load_rsp)
        begin
            rsp_next.fill_count = fill_wide[FILL_W-1:0];
            rsp_valid_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        hit_reg <= hit_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== tb/skit_checker.sv =====
// ----------------------------------------------------------------------------
// skit_checker
// watches both channels of the sorted key index table, keeps its own sorted
// copy of the entries and compares every result with the predicted one
// ----------------------------------------------------------------------------
module skit_checker
    import skit_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   failures,
    output int   outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    entry_t sorted_entries [CAPACITY];
    int     entries_held = 0;
    rsp_t   pending_rsp [$];

    initial begin
        failures    = 0;
        outstanding = 0;
    end

    // apply one request to the shadow table and return the result it gives
    function automatic rsp_t apply_table_op(req_t r);
        rsp_t res;
        int   slot;
        bit   hit;
        res        = '0;
        res.status = ST_OK;
        case (r.func)
            FUNC_INSERT: begin
                if (entries_held >= CAPACITY) begin
                    res.status = ST_FULL;
                end
                else begin
                    // new entry goes after every key less than or equal to it
                    slot = entries_held;
                    while (slot > 0 && sorted_entries[slot-1].key > r.key) begin
                        sorted_entries[slot] = sorted_entries[slot-1];
                        slot--;
                    end
                    sorted_entries[slot] = '{key: r.key, offset: r.entry_offset,
                                             size: r.entry_size};
                    entries_held++;
                end
            end
            FUNC_LOOKUP: begin
                hit = 1'b0;
                for (int i = 0; i < entries_held; i++) begin
                    if (!hit && sorted_entries[i].key == r.key) begin
                        hit              = 1'b1;
                        res.position     = i[POS_W-1:0];
                        res.found_offset = sorted_entries[i].offset;
                        res.found_size   = sorted_entries[i].size;
                    end
                end
                if (!hit)
                    res.status = ST_MISS;
            end
            FUNC_CLEAR: begin
                entries_held = 0;
            end
            default: begin
            end
        endcase
        res.fill_count = entries_held[FILL_W-1:0];
        return res;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            failures++;
        end
    endtask

    always @(posedge clk) begin
        rsp_t want;
        if (rst_n) begin
            // results are checked before the request of the same edge is queued
            if (rsp_valid && rsp_ready) begin
                if (pending_rsp.size() == 0) begin
                    $error("result with no request waiting: 0x%0h", rsp);
                    failures++;
                end
                else begin
                    want = pending_rsp.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("position", want.position, rsp.position);
                    check_field("found_offset", want.found_offset, rsp.found_offset);
                    check_field("found_size", want.found_size, rsp.found_size);
                    check_field("fill_count", want.fill_count, rsp.fill_count);
                end
            end
            if (req_valid && req_ready)
                pending_rsp.push_back(apply_table_op(req));
            outstanding <= pending_rsp.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives insert, lookup, clear and unused requests into the sorted key index table
// under changing back-pressure; a checker beside the block predicts results
// ----------------------------------------------------------------------------
module testbench
    import skit_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         TABLE_DEPTH     = 256;
    localparam logic [1:0] FUNC_UNUSED     = 2'd3;
    localparam logic [30:0] KEY_MAX        = 31'h7FFF_FFFF;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         STALL_LIMIT     = 4000;
    localparam int         TAIL_CYCLES     = 8;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int failures;
    int outstanding;

    // idle percentages, changed per phase
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // set by the request side to make the receiver hold off for a long stretch
    bit hold_off_req = 1'b0;

    // keys held in the table, only used to steer lookups toward hits
    logic [30:0] live_keys [$];

    sorted_key_index_table #(
        .CAPACITY (TABLE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    skit_checker #(
        .CAPACITY (TABLE_DEPTH)
    ) checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // receiver: random ready, or a long hold-off on demand
    initial begin
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                rsp_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: too long without any handshake ends the run
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // offer one request, with a random gap before it, and wait for acceptance
    task automatic send(logic [1:0] func, logic [30:0] key, logic [31:0] offset,
                        logic [15:0] size);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{func: func, key: key, entry_offset: offset, entry_size: size};
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        // track what should be held, for steering only
        if (func == FUNC_INSERT && live_keys.size() < TABLE_DEPTH)
            live_keys.push_back(key);
        else if (func == FUNC_CLEAR)
            live_keys.delete();
    endtask

    // sender pause until every result is back
    task automatic drain_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // half the time a small pool or zero so that equal keys pile up
    function automatic logic [30:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return 31'($urandom_range(63));
        else if (r < 50)
            return '0;
        else
            return 31'($urandom_range(32'h7FFF_FFFE));
    endfunction

    function automatic logic [30:0] lookup_key();
        if (live_keys.size() > 0 && $urandom_range(99) < 60)
            return live_keys[$urandom_range(live_keys.size() - 1)];
        return pick_key();
    endfunction

    task automatic send_insert(logic [30:0] key);
        send(FUNC_INSERT, key, $urandom, 16'($urandom_range(16'hFFFF)));
    endtask

    task automatic send_lookup(logic [30:0] key);
        send(FUNC_LOOKUP, key, $urandom, 16'($urandom_range(16'hFFFF)));
    endtask

    // extremes, duplicates, unused code, clear and lookups on an empty table
    task automatic directed_requests();
        send(FUNC_LOOKUP, '0, '0, '0);                  // miss on empty table
        send(FUNC_UNUSED, '0, '0, '0);
        send(FUNC_INSERT, KEY_MAX, 32'hFFFF_FFFF, 16'hFFFF);
        send(FUNC_INSERT, '0, '0, '0);
        send(FUNC_INSERT, '0, 32'h1234_5678, 16'h0001); // equal key goes after
        send(FUNC_INSERT, 31'h4000_0000, 32'h8000_0000, 16'h8000);
        send(FUNC_LOOKUP, '0, '0, '0);                  // first of the equal keys
        send(FUNC_LOOKUP, KEY_MAX, '0, '0);
        send(FUNC_LOOKUP, 31'h4000_0000, '0, '0);
        send(FUNC_LOOKUP, 31'd1, '0, '0);
        send(FUNC_LOOKUP, 31'h7FFF_FFFE, '0, '0);
        send(FUNC_UNUSED, KEY_MAX, 32'hFFFF_FFFF, 16'hFFFF);
        send(FUNC_INSERT, KEY_MAX, 32'hA5A5_A5A5, 16'h5A5A);
        send(FUNC_LOOKUP, KEY_MAX, 32'hFFFF_FFFF, 16'hFFFF);
        send(FUNC_CLEAR, KEY_MAX, 32'hFFFF_FFFF, 16'hFFFF);
        send(FUNC_LOOKUP, KEY_MAX, '0, '0);             // miss after clear
        send(FUNC_CLEAR, '0, '0, '0);                   // clear of an empty table
        send(FUNC_INSERT, 31'd5, 32'h0000_00FF, 16'h00FF);
        send(FUNC_LOOKUP, 31'd5, '0, '0);
        send(FUNC_CLEAR, '0, '0, '0);
    endtask

    // fill the table to the top, hit it while full, then clear
    task automatic fill_round(bit with_hold_off);
        while (live_keys.size() < TABLE_DEPTH - 1) begin
            if (with_hold_off && live_keys.size() == 50)
                hold_off_req = 1'b1;
            if ($urandom_range(99) < 75)
                send_insert(pick_key());
            else
                send_lookup(lookup_key());
        end
        // largest key last so that a lookup lands on the top position
        send_insert(KEY_MAX);
        repeat (6) send_insert(pick_key());            // refused, table full
        send_lookup(KEY_MAX);
        repeat (9) send_lookup(lookup_key());
        send(FUNC_CLEAR, pick_key(), $urandom, 16'($urandom_range(16'hFFFF)));
    endtask

    // short mix on a lightly filled table, with clears and unused codes
    task automatic mixed_round(int n_requests);
        int r;
        repeat (n_requests) begin
            r = $urandom_range(99);
            if (r < 3)
                send(FUNC_CLEAR, pick_key(), $urandom, 16'($urandom_range(16'hFFFF)));
            else if (r < 6)
                send(FUNC_UNUSED, 31'($urandom), $urandom, 16'($urandom_range(16'hFFFF)));
            else if (r < 50)
                send_insert(pick_key());
            else
                send_lookup(lookup_key());
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++) begin
            // sender busy and receiver slow, then the reverse, then flat out
            case (phase)
                0: begin
                    send_idle_pct = 17;
                    recv_idle_pct = 75;
                end
                1: begin
                    send_idle_pct = 75;
                    recv_idle_pct = 17;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0)
                directed_requests();
            fill_round(phase == 2);
            mixed_round(60);
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sorted_key_index_table.f =====
rtl/core/skit_pkg.sv
rtl/core/skit_cell.sv
rtl/core/skit_reduce.sv
rtl/core/sorted_key_index_table.sv
tb/skit_checker.sv
tb/testbench.sv
